// ===== rtl/peu_pkg.sv =====
package peu_pkg;

   localparam int AXIS_W     = 20;
   localparam int LANES      = 3;
   localparam int DT_W       = 12;
   localparam int MASS_W     = 20;
   localparam int LIFE_W     = 16;
   localparam int SCALE_W    = 32;
   localparam int COLOR_W    = 48;
   localparam int COMP_W     = 16;
   localparam int VEC_W      = AXIS_W * LANES;
   localparam int QUO_W      = 2 * AXIS_W;
   localparam int LANE_LAT   = QUO_W + 7;
   localparam int TOTAL_LAT  = LANE_LAT + 1;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG      = 2'd3;

   localparam logic [DT_W-1:0]   DT_RESET   = 12'd68;
   localparam logic [MASS_W-1:0] MASS_RESET = 20'd4096;

   localparam logic [COMP_W-1:0] SHRINK_Q16 = 16'd39322;
   localparam logic [COMP_W-1:0] FADE_Q16   = 16'd52429;
   localparam logic signed [17:0] REMOVE_LIMIT = -18'sd2732;

   typedef logic signed [AXIS_W-1:0] axis_type;

   typedef struct packed {
      logic [LIFE_W-1:0]  life;
      logic [SCALE_W-1:0] scale;
      logic [COLOR_W-1:0] color;
      logic               remove;
   } fx_type;

   function automatic axis_type sat_axis(input logic signed [41:0] x);
      if (x > 42'sd524287) begin
         return 20'sd524287;
      end else if (x < -42'sd524288) begin
         return -20'sd524288;
      end
      return x[AXIS_W-1:0];
   endfunction

endpackage

// ===== rtl/peu_lane.sv =====
module peu_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  peu_pkg::axis_type             pos,
   input  peu_pkg::axis_type             vel,
   input  peu_pkg::axis_type             acc,
   input  peu_pkg::axis_type             grav,
   input  peu_pkg::axis_type             drag,
   input  logic [peu_pkg::MASS_W-1:0]    mass,
   input  logic [peu_pkg::DT_W-1:0]      dt,
   output logic                          out_valid,
   output peu_pkg::axis_type             pos_out,
   output peu_pkg::axis_type             vel_out,
   output peu_pkg::axis_type             acc_out
);

   localparam int QW = peu_pkg::QUO_W;
   localparam int MW = peu_pkg::MASS_W;

   logic                     vld1_ff;
   logic signed [40:0]       gm1_ff;
   logic signed [39:0]       dv1_ff;
   peu_pkg::axis_type        a1_ff, v1_ff, p1_ff;

   logic                     vld_ff [0:QW];
   logic [MW-1:0]            rem_ff [0:QW];
   logic [QW-1:0]            quo_ff [0:QW];
   logic                     neg_ff [0:QW];
   peu_pkg::axis_type        ad_ff  [0:QW];
   peu_pkg::axis_type        vd_ff  [0:QW];
   peu_pkg::axis_type        pd_ff  [0:QW];

   logic signed [41:0]       force_in;
   logic [41:0]              mag_in;

   logic                     vlda_ff, vldpa_ff, vldv_ff, vldpv_ff, vldp_ff;
   peu_pkg::axis_type        aa_ff, va_ff, pa_ff;
   logic signed [32:0]       prda_ff;
   peu_pkg::axis_type        ab_ff, vb_ff, pb_ff;
   peu_pkg::axis_type        ac_ff, vc_ff, pc_ff;
   logic signed [32:0]       prdv_ff;
   peu_pkg::axis_type        ap_ff, vp_ff, pp_ff;
   peu_pkg::axis_type        ae_ff, ve_ff, pe_ff;

   logic signed [40:0]       q_in;
   logic signed [41:0]       asum_in, vsum_in, psum_in;
   logic signed [32:0]       dta_in, dtv_in;

   always_comb begin
      force_in = {gm1_ff[40], gm1_ff} - {{2{dv1_ff[39]}}, dv1_ff};
      mag_in   = force_in[41] ? -force_in : force_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         vld1_ff   <= in_valid;
         vld_ff[0] <= vld1_ff;
      end
      gm1_ff    <= grav * $signed({1'b0, mass});
      dv1_ff    <= drag * vel;
      a1_ff     <= acc;
      v1_ff     <= vel;
      p1_ff     <= pos;
      rem_ff[0] <= '0;
      quo_ff[0] <= mag_in[QW-1:0];
      neg_ff[0] <= force_in[41];
      ad_ff[0]  <= a1_ff;
      vd_ff[0]  <= v1_ff;
      pd_ff[0]  <= p1_ff;
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [MW:0] trial;
      logic        ge;
      logic [MW:0] diff;
      always_comb begin
         trial = {rem_ff[k], quo_ff[k][QW-1]};
         ge    = trial >= {1'b0, mass};
         diff  = trial - {1'b0, mass};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
         quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
         neg_ff[k+1] <= neg_ff[k];
         ad_ff[k+1]  <= ad_ff[k];
         vd_ff[k+1]  <= vd_ff[k];
         pd_ff[k+1]  <= pd_ff[k];
      end
   end

   always_comb begin
      if (mass == '0) begin
         q_in = '0;
      end else if (neg_ff[QW]) begin
         q_in = -$signed({1'b0, quo_ff[QW]});
      end else begin
         q_in = $signed({1'b0, quo_ff[QW]});
      end
      asum_in = {{22{ad_ff[QW][19]}}, ad_ff[QW]} + {q_in[40], q_in};
      dta_in  = (prda_ff + 33'sd2048) >>> 12;
      vsum_in = {{22{vb_ff[19]}}, vb_ff} + {{9{dta_in[32]}}, dta_in};
      dtv_in  = (prdv_ff + 33'sd2048) >>> 12;
      psum_in = {{22{pp_ff[19]}}, pp_ff} + {{9{dtv_in[32]}}, dtv_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff  <= 1'b0;
         vldpa_ff <= 1'b0;
         vldv_ff  <= 1'b0;
         vldpv_ff <= 1'b0;
         vldp_ff  <= 1'b0;
      end else begin
         vlda_ff  <= vld_ff[QW];
         vldpa_ff <= vlda_ff;
         vldv_ff  <= vldpa_ff;
         vldpv_ff <= vldv_ff;
         vldp_ff  <= vldpv_ff;
      end
      aa_ff   <= peu_pkg::sat_axis(asum_in);
      va_ff   <= vd_ff[QW];
      pa_ff   <= pd_ff[QW];
      prda_ff <= aa_ff * $signed({1'b0, dt});
      ab_ff   <= aa_ff;
      vb_ff   <= va_ff;
      pb_ff   <= pa_ff;
      ac_ff   <= ab_ff;
      vc_ff   <= peu_pkg::sat_axis(vsum_in);
      pc_ff   <= pb_ff;
      prdv_ff <= vc_ff * $signed({1'b0, dt});
      ap_ff   <= ac_ff;
      vp_ff   <= vc_ff;
      pp_ff   <= pc_ff;
      ae_ff   <= ap_ff;
      ve_ff   <= vp_ff;
      pe_ff   <= peu_pkg::sat_axis(psum_in);
   end

   assign out_valid = vldp_ff;
   assign pos_out   = pe_ff;
   assign vel_out   = ve_ff;
   assign acc_out   = ae_ff;

endmodule

// ===== rtl/peu_fx.sv =====
module peu_fx (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [peu_pkg::LIFE_W-1:0]    life,
   input  logic [peu_pkg::SCALE_W-1:0]   scale,
   input  logic [peu_pkg::COLOR_W-1:0]   color,
   input  logic [1:0]                    flags,
   input  logic [peu_pkg::DT_W-1:0]      dt,
   output logic                          out_valid,
   output peu_pkg::fx_type               fx_out
);

   localparam int DEPTH = peu_pkg::LANE_LAT - 1;

   logic                     vld1_ff;
   logic                     shrink1_ff, fade1_ff;
   logic [15:0]              life1_ff;
   logic                     rm1_ff;
   logic [31:0]              sprd_ff [0:1];
   logic [31:0]              cprd_ff [0:2];
   logic [31:0]              scale1_ff;
   logic [47:0]              color1_ff;

   logic                     vld_ff [0:DEPTH-1];
   peu_pkg::fx_type          dly_ff [0:DEPTH-1];

   logic signed [16:0]       lifea_in;
   logic signed [17:0]       lifeb_in;
   logic [15:0]              lsat_in;
   peu_pkg::fx_type          fx_in;
   logic [32:0]              rnd [0:4];

   always_comb begin
      lifea_in = $signed({life[15], life}) - $signed({5'b0, dt});
      lifeb_in = {lifea_in[16], lifea_in} - $signed({6'b0, dt});
      if (lifeb_in < -18'sd32768) begin
         lsat_in = 16'h8000;
      end else begin
         lsat_in = lifeb_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      shrink1_ff <= flags[0] & lifea_in[16];
      fade1_ff   <= flags[1] & lifea_in[16];
      life1_ff   <= lsat_in;
      rm1_ff     <= lifeb_in < peu_pkg::REMOVE_LIMIT;
      scale1_ff  <= scale;
      color1_ff  <= color;
      sprd_ff[0] <= scale[15:0]  * peu_pkg::SHRINK_Q16;
      sprd_ff[1] <= scale[31:16] * peu_pkg::SHRINK_Q16;
      cprd_ff[0] <= color[15:0]  * peu_pkg::FADE_Q16;
      cprd_ff[1] <= color[31:16] * peu_pkg::FADE_Q16;
      cprd_ff[2] <= color[47:32] * peu_pkg::FADE_Q16;
   end

   always_comb begin
      rnd[0] = {1'b0, sprd_ff[0]} + 33'd32768;
      rnd[1] = {1'b0, sprd_ff[1]} + 33'd32768;
      rnd[2] = {1'b0, cprd_ff[0]} + 33'd32768;
      rnd[3] = {1'b0, cprd_ff[1]} + 33'd32768;
      rnd[4] = {1'b0, cprd_ff[2]} + 33'd32768;
      fx_in.life   = life1_ff;
      fx_in.remove = rm1_ff;
      fx_in.scale  = shrink1_ff ? {rnd[1][31:16], rnd[0][31:16]} : scale1_ff;
      fx_in.color  = fade1_ff ? {rnd[4][31:16], rnd[3][31:16], rnd[2][31:16]}
                              : color1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld1_ff;
      end
      dly_ff[0] <= fx_in;
   end

   for (genvar j = 1; j < DEPTH; j++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_ff[j-1];
         end
         dly_ff[j] <= dly_ff[j-1];
      end
   end

   assign out_valid = vld_ff[DEPTH-1];
   assign fx_out    = dly_ff[DEPTH-1];

   logic unused_rnd;
   assign unused_rnd = rnd[0][32] | rnd[1][32] | rnd[2][32] | rnd[3][32] | rnd[4][32];

endmodule

// ===== rtl/particle_euler_update.sv =====
// Throughput: one particle per cycle while busy is low; busy is high during reset
// and in the cycle after reset is released.
// Latency is set by the 40-stage pipelined force/mass divider in each axis lane.
// Reset: synchronous, clears all valid bits and loads register defaults.
// Results cannot be stalled; each is shown for exactly one cycle.
module particle_euler_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [peu_pkg::VEC_W-1:0]       req_position_in,
   input  logic [peu_pkg::VEC_W-1:0]       req_velocity_in,
   input  logic [peu_pkg::VEC_W-1:0]       req_accel_in,
   input  logic signed [peu_pkg::LIFE_W-1:0] req_life_in,
   input  logic [peu_pkg::SCALE_W-1:0]     req_scale_in,
   input  logic [peu_pkg::COLOR_W-1:0]     req_color_in,
   input  logic [1:0]                      req_effect_flags,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [peu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [peu_pkg::VEC_W-1:0]       csr_wdata,
   output logic                            rsp_strobe,
   output logic [peu_pkg::VEC_W-1:0]       rsp_position_out,
   output logic [peu_pkg::VEC_W-1:0]       rsp_velocity_out,
   output logic [peu_pkg::VEC_W-1:0]       rsp_accel_out,
   output logic signed [peu_pkg::LIFE_W-1:0] rsp_life_out,
   output logic [peu_pkg::SCALE_W-1:0]     rsp_scale_out,
   output logic [peu_pkg::COLOR_W-1:0]     rsp_color_out,
   output logic                            rsp_remove_particle
);

   localparam int AW = peu_pkg::AXIS_W;
   localparam int NL = peu_pkg::LANES;

   logic                          busy_ff;
   logic                          accept;
   logic [peu_pkg::DT_W-1:0]      dt_ff;
   logic [peu_pkg::MASS_W-1:0]    mass_ff;
   logic [peu_pkg::VEC_W-1:0]     grav_ff, drag_ff;

   logic [NL-1:0]                 lane_vld;
   logic [peu_pkg::VEC_W-1:0]     pos_pk, vel_pk, acc_pk;
   logic                          fx_vld;
   peu_pkg::fx_type               fx;

   logic                          strobe_ff;
   logic [peu_pkg::VEC_W-1:0]     pos_ff, vel_ff, acc_ff;
   peu_pkg::fx_type               fxo_ff;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         dt_ff   <= peu_pkg::DT_RESET;
         mass_ff <= peu_pkg::MASS_RESET;
         grav_ff <= '0;
         drag_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               peu_pkg::CSR_TIME_STEP: dt_ff   <= csr_wdata[peu_pkg::DT_W-1:0];
               peu_pkg::CSR_MASS:      mass_ff <= csr_wdata[peu_pkg::MASS_W-1:0];
               peu_pkg::CSR_GRAVITY:   grav_ff <= csr_wdata;
               peu_pkg::CSR_DRAG:      drag_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   for (genvar k = 0; k < NL; k++) begin : g_lane
      peu_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .pos       (req_position_in[AW*k +: AW]),
         .vel       (req_velocity_in[AW*k +: AW]),
         .acc       (req_accel_in[AW*k +: AW]),
         .grav      (grav_ff[AW*k +: AW]),
         .drag      (drag_ff[AW*k +: AW]),
         .mass      (mass_ff),
         .dt        (dt_ff),
         .out_valid (lane_vld[k]),
         .pos_out   (pos_pk[AW*k +: AW]),
         .vel_out   (vel_pk[AW*k +: AW]),
         .acc_out   (acc_pk[AW*k +: AW])
      );
   end

   peu_fx u_fx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .life      (req_life_in),
      .scale     (req_scale_in),
      .color     (req_color_in),
      .flags     (req_effect_flags),
      .dt        (dt_ff),
      .out_valid (fx_vld),
      .fx_out    (fx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fx_vld;
      end
      pos_ff <= pos_pk;
      vel_ff <= vel_pk;
      acc_ff <= acc_pk;
      fxo_ff <= fx;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_position_out    = pos_ff;
   assign rsp_velocity_out    = vel_ff;
   assign rsp_accel_out       = acc_ff;
   assign rsp_life_out        = fxo_ff.life;
   assign rsp_scale_out       = fxo_ff.scale;
   assign rsp_color_out       = fxo_ff.color;
   assign rsp_remove_particle = fxo_ff.remove;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(peu_pkg::TOTAL_LAT) rsp_strobe)
      else $error("result missing after fixed latency");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      lane_vld == {NL{fx_vld}})
      else $error("axis lanes out of step with sideband");

   a_remove: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_remove_particle == (rsp_life_out < -16'sd2732)))
      else $error("remove flag disagrees with lifetime");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 2000;

   typedef logic [peu_pkg::VEC_W-1:0] vec_type;

   typedef struct {
      logic [peu_pkg::VEC_W-1:0]   pos;
      logic [peu_pkg::VEC_W-1:0]   vel;
      logic [peu_pkg::VEC_W-1:0]   acc;
      logic [peu_pkg::LIFE_W-1:0]  life;
      logic [peu_pkg::SCALE_W-1:0] scale;
      logic [peu_pkg::COLOR_W-1:0] color;
      logic                        remove;
   } particle_state_type;

   class euler_scoreboard;
      logic [peu_pkg::DT_W-1:0]   dt;
      logic [peu_pkg::MASS_W-1:0] mass;
      logic [peu_pkg::VEC_W-1:0]  gravity;
      logic [peu_pkg::VEC_W-1:0]  drag;
      particle_state_type         pending[$];
      int                         mismatches;
      int                         matched;

      function new();
         dt = peu_pkg::DT_RESET;
         mass = peu_pkg::MASS_RESET;
         gravity = '0;
         drag = '0;
         mismatches = 0;
         matched = 0;
      endfunction

      function void write_reg(logic [peu_pkg::CSR_IDX_W-1:0] idx,
                              logic [peu_pkg::VEC_W-1:0] val);
         case (idx)
            peu_pkg::CSR_TIME_STEP: dt = val[peu_pkg::DT_W-1:0];
            peu_pkg::CSR_MASS:      mass = val[peu_pkg::MASS_W-1:0];
            peu_pkg::CSR_GRAVITY:   gravity = val;
            peu_pkg::CSR_DRAG:      drag = val;
            default: ;
         endcase
      endfunction

      function longint round_q12(longint x);
         return (x + 2048) >>> 12;
      endfunction

      function longint clamp_axis(longint x);
         if (x > 524287) return 524287;
         if (x < -524288) return -524288;
         return x;
      endfunction

      function logic [63:0] scale_comps(logic [63:0] v, int n, longint f);
         logic [63:0] r;
         longint c;
         r = '0;
         for (int k = 0; k < n; k++) begin
            c = (longint'(v[16*k +: 16]) * f + 32768) >>> 16;
            r[16*k +: 16] = c[15:0];
         end
         return r;
      endfunction

      function void note_particle(logic [peu_pkg::VEC_W-1:0] p, logic [peu_pkg::VEC_W-1:0] v,
                                  logic [peu_pkg::VEC_W-1:0] a,
                                  logic [peu_pkg::LIFE_W-1:0] life,
                                  logic [peu_pkg::SCALE_W-1:0] sc,
                                  logic [peu_pkg::COLOR_W-1:0] col,
                                  logic [1:0] fl);
         particle_state_type e;
         longint d, m, l1, l2, pa, va, aa, g, dr, frc, add;
         logic [63:0] tmp;
         d = longint'(dt);
         m = longint'(mass);
         l1 = longint'($signed(life)) - d;
         e.scale = sc;
         e.color = col;
         if (l1 < 0) begin
            if (fl[0]) begin
               tmp = scale_comps({32'd0, sc}, 2, longint'(peu_pkg::SHRINK_Q16));
               e.scale = tmp[31:0];
            end
            if (fl[1]) begin
               tmp = scale_comps({16'd0, col}, 3, longint'(peu_pkg::FADE_Q16));
               e.color = tmp[47:0];
            end
         end
         for (int k = 0; k < peu_pkg::LANES; k++) begin
            pa = longint'($signed(p[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W]));
            va = longint'($signed(v[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W]));
            aa = longint'($signed(a[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W]));
            g  = longint'($signed(gravity[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W]));
            dr = longint'($signed(drag[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W]));
            frc = g * m - dr * va;
            add = (m != 0) ? frc / m : 0;
            aa = clamp_axis(aa + add);
            va = clamp_axis(va + round_q12(aa * d));
            pa = clamp_axis(pa + round_q12(va * d));
            e.pos[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = pa[peu_pkg::AXIS_W-1:0];
            e.vel[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = va[peu_pkg::AXIS_W-1:0];
            e.acc[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = aa[peu_pkg::AXIS_W-1:0];
         end
         l2 = l1 - d;
         e.remove = (l2 < longint'(peu_pkg::REMOVE_LIMIT));
         if (l2 < -32768) l2 = -32768;
         if (l2 > 32767) l2 = 32767;
         e.life = l2[15:0];
         pending.push_back(e);
      endfunction

      function void check_result(particle_state_type got);
         particle_state_type e;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         bad = (got.pos !== e.pos) || (got.vel !== e.vel) || (got.acc !== e.acc) ||
               (got.life !== e.life) || (got.scale !== e.scale) ||
               (got.color !== e.color) || (got.remove !== e.remove);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at %0t", $realtime);
               $display("  pos exp %h got %h  vel exp %h got %h",
                        e.pos, got.pos, e.vel, got.vel);
               $display("  acc exp %h got %h  life exp %h got %h",
                        e.acc, got.acc, e.life, got.life);
               $display("  scale exp %h got %h  color exp %h got %h  rm exp %b got %b",
                        e.scale, got.scale, e.color, got.color, e.remove, got.remove);
            end
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [peu_pkg::VEC_W-1:0] req_position_in = '0, req_velocity_in = '0, req_accel_in = '0;
   logic signed [peu_pkg::LIFE_W-1:0] req_life_in = '0;
   logic [peu_pkg::SCALE_W-1:0] req_scale_in = '0;
   logic [peu_pkg::COLOR_W-1:0] req_color_in = '0;
   logic [1:0] req_effect_flags = '0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [peu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [peu_pkg::VEC_W-1:0] csr_wdata = '0;
   logic rsp_strobe;
   logic [peu_pkg::VEC_W-1:0] rsp_position_out, rsp_velocity_out, rsp_accel_out;
   logic signed [peu_pkg::LIFE_W-1:0] rsp_life_out;
   logic [peu_pkg::SCALE_W-1:0] rsp_scale_out;
   logic [peu_pkg::COLOR_W-1:0] rsp_color_out;
   logic rsp_remove_particle;

   euler_scoreboard sb = new();
   int idle_cycles = 0;
   int removals = 0;
   int phases = 0;

   particle_euler_update dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      particle_state_type got;
      if (!reset) begin
         if (start && !busy) begin
            sb.note_particle(req_position_in, req_velocity_in, req_accel_in, req_life_in,
                             req_scale_in, req_color_in, req_effect_flags);
         end
         if (rsp_strobe) begin
            got.pos = rsp_position_out;
            got.vel = rsp_velocity_out;
            got.acc = rsp_accel_out;
            got.life = rsp_life_out;
            got.scale = rsp_scale_out;
            got.color = rsp_color_out;
            got.remove = rsp_remove_particle;
            if (rsp_remove_particle) removals++;
            sb.check_result(got);
         end
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic logic [peu_pkg::VEC_W-1:0] rand_vec();
      logic [peu_pkg::VEC_W-1:0] v;
      for (int k = 0; k < peu_pkg::LANES; k++) begin
         case ($urandom_range(0, 5))
            0: v[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = 20'h7FFFF;
            1: v[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = 20'h80000;
            2: v[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = 20'($urandom_range(0, 8191) - 4096);
            default: v[peu_pkg::AXIS_W*k +: peu_pkg::AXIS_W] = 20'($urandom());
         endcase
      end
      return v;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic write_csr(logic [peu_pkg::CSR_IDX_W-1:0] idx,
                            logic [peu_pkg::VEC_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic send_particle(logic [peu_pkg::VEC_W-1:0] p, logic [peu_pkg::VEC_W-1:0] v,
                                logic [peu_pkg::VEC_W-1:0] a,
                                logic [peu_pkg::LIFE_W-1:0] life,
                                logic [peu_pkg::SCALE_W-1:0] sc,
                                logic [peu_pkg::COLOR_W-1:0] col,
                                logic [1:0] fl, bit gaps);
      int g;
      req_position_in <= p;
      req_velocity_in <= v;
      req_accel_in <= a;
      req_life_in <= life;
      req_scale_in <= sc;
      req_color_in <= col;
      req_effect_flags <= fl;
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         start <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic send_random(bit gaps);
      logic [peu_pkg::LIFE_W-1:0] life;
      case ($urandom_range(0, 4))
         0: life = 16'h7FFF;
         1: life = 16'h8000;
         2: life = 16'($urandom_range(0, 16383) - 8192);
         default: life = 16'($urandom());
      endcase
      send_particle(rand_vec(), rand_vec(), rand_vec(), life, $urandom(),
                    48'({$urandom(), $urandom()}), 2'($urandom_range(0, 3)), gaps);
   endtask

   task automatic drain();
      start <= 0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (peu_pkg::TOTAL_LAT + 4) @(negedge clock);
      phases++;
   endtask

   task automatic random_config();
      write_csr(peu_pkg::CSR_TIME_STEP, ($urandom_range(0, 3) == 0) ?
                vec_type'(12'hFFF) : vec_type'($urandom_range(0, 4095)));
      write_csr(peu_pkg::CSR_MASS, ($urandom_range(0, 3) == 0) ?
                vec_type'(20'hFFFFF) : vec_type'($urandom_range(1, 1048575)));
      write_csr(peu_pkg::CSR_GRAVITY, rand_vec());
      write_csr(peu_pkg::CSR_DRAG, rand_vec());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, both flags, death boundary, underflow
      send_particle('0, '0, '0, 16'sd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 2'b11, 0);
      send_particle({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}}, 16'sh7FFF,
                    32'h1234_5678, 48'h8000_0001_7FFF, 2'b11, 0);
      send_particle({3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}}, 16'sh8000,
                    32'hFFFF_0001, 48'hFFFF_0000_8000, 2'b01, 0);
      send_particle('0, '0, '0, 16'sd68, 32'h1000_1000, 48'h1, 2'b11, 0);
      send_particle('0, '0, '0, 16'sd67, 32'h1000_1000, 48'h1, 2'b10, 0);
      send_particle('0, '0, '0, -16'sd2597, 32'h0, 48'h0, 2'b00, 0);
      send_particle('0, '0, '0, -16'sd2596, 32'h1, 48'h1, 2'b01, 0);
      drain();

      write_csr(peu_pkg::CSR_TIME_STEP, vec_type'(12'hFFF));
      write_csr(peu_pkg::CSR_MASS, vec_type'(20'hFFFFF));
      write_csr(peu_pkg::CSR_GRAVITY, {3{20'h7FFFF}});
      write_csr(peu_pkg::CSR_DRAG, {3{20'h80000}});
      for (int i = 0; i < 8; i++) send_random(0);
      drain();

      write_csr(peu_pkg::CSR_TIME_STEP, vec_type'(12'd0));
      write_csr(peu_pkg::CSR_MASS, vec_type'(20'd1));
      write_csr(peu_pkg::CSR_GRAVITY, {3{20'h80000}});
      write_csr(peu_pkg::CSR_DRAG, {3{20'h7FFFF}});
      for (int i = 0; i < 8; i++) send_random(0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         for (int i = 0; i < N_RANDOM / 8; i++) send_random(ph != 3);
         drain();
      end

      $display("%0d particles checked over %0d register settings, %0d marked for removal",
               sb.matched + sb.mismatches, phases, removals);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/peu_pkg.sv
rtl/peu_lane.sv
rtl/peu_fx.sv
rtl/particle_euler_update.sv
verif/tb.sv
